// ===== rtl/pli_pkg.sv =====
package pli_pkg;

   // field widths of the item channels
   localparam int OP_W      = 3;
   localparam int POS_W     = 5;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int COUNT_W   = 5;
   localparam int INDEX_W   = 4;

   // read all emits at most this many result items
   localparam int MAX_RESULTS = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT      = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE       = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_ALL    = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   // per-cell source select
   localparam int CELL_SEL_W = 3;
   localparam logic [CELL_SEL_W-1:0] CELL_HOLD  = 3'd0;
   localparam logic [CELL_SEL_W-1:0] CELL_LOAD  = 3'd1;
   localparam logic [CELL_SEL_W-1:0] CELL_LEFT  = 3'd2;
   localparam logic [CELL_SEL_W-1:0] CELL_RIGHT = 3'd3;
   localparam logic [CELL_SEL_W-1:0] CELL_HEAD  = 3'd4;

   typedef logic [VAL_W-1:0] word_type;

endpackage

// ===== rtl/pli_cell.sv =====
module pli_cell (
   input  logic                           clock,
   input  logic [pli_pkg::CELL_SEL_W-1:0] sel,
   input  pli_pkg::word_type              load_val,
   input  pli_pkg::word_type              left_val,
   input  pli_pkg::word_type              right_val,
   input  pli_pkg::word_type              head_val,
   output pli_pkg::word_type              val
);
   import pli_pkg::*;

   word_type val_ff;
   word_type val_in;

   always_comb begin
      case (sel)
         CELL_HOLD:  val_in = val_ff;
         CELL_LOAD:  val_in = load_val;
         CELL_LEFT:  val_in = left_val;
         CELL_RIGHT: val_in = right_val;
         CELL_HEAD:  val_in = head_val;
         default:    val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

// ===== rtl/positional_list_insert_erase.sv =====
// Positional list of signed 32-bit words held in a row of CAPACITY cells.
// Request channel (req_valid / req_stall) carries one operation per item:
// append, remove last, insert at position, erase at position, read all.
// Response channel (rsp_valid / rsp_stall) returns result items from one
// output register; each carries status and the count after the operation.
// Edits: the cells from the edit position on shift in parallel in the cycle
// the item is taken, and one result item appears in the next cycle. A new item is
// taken every cycle while the receiver keeps up, so edits run at one per cycle.
// Read all: the row rotates by one cell per cycle while the receiver keeps up,
// and the head cell is emitted each step; the item first sets the busy flag,
// then each head cell is registered in the output register, and req_stall stays
// high until every stored word has rotated, so no new item is taken meanwhile.
// Up to 16 result items, the last one flagged; words beyond the sixteenth are
// rotated through without output so the list ends in its original order.
// Read all on an empty list gives a single item with status empty.
// When the receiver stalls, the output register holds its item and
// req_stall is raised until it is taken; a read all pauses its rotation while it still has items to emit.
// Reset (synchronous, active high) empties the list and drops any pending
// result; cell contents are left as they are and are never read.
module positional_list_insert_erase #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pli_pkg::OP_W-1:0]           req_op,
   input  logic [pli_pkg::POS_W-1:0]          req_position,
   input  logic signed [pli_pkg::VAL_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pli_pkg::STAT_W-1:0]         rsp_status,
   output logic [pli_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_has_value,
   output logic [pli_pkg::INDEX_W-1:0]        rsp_item_index,
   output logic signed [pli_pkg::VAL_W-1:0]   rsp_item_value,
   output logic                               rsp_last
);
   import pli_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]      count_ff, count_in;
   logic               busy_ff, busy_in;
   logic [CW-1:0]      step_ff, step_in;

   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_has_value_ff, rsp_has_value_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   word_type           rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   word_type           cell_val [CAPACITY];

   logic               do_insert, do_erase, do_rotate;
   logic [CW-1:0]      edit_pos;
   logic [PW-1:0]      pos_ext, cnt_ext, ins_pos;
   logic               rsp_free, req_accept, rsp_load;
   int                 n_emit;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy_ff || !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign pos_ext = PW'(req_position);
   assign cnt_ext = PW'(count_ff);
   assign n_emit  = (int'(count_ff) > MAX_RESULTS) ? MAX_RESULTS : int'(count_ff);

   always_comb begin
      count_in         = count_ff;
      busy_in          = busy_ff;
      step_in          = step_ff;
      do_insert        = 1'b0;
      do_erase         = 1'b0;
      do_rotate        = 1'b0;
      edit_pos         = '0;
      ins_pos          = '0;
      rsp_load         = 1'b0;
      rsp_status_in    = ST_OK;
      rsp_count_in     = COUNT_W'(count_ff);
      rsp_has_value_in = 1'b0;
      rsp_index_in     = '0;
      rsp_value_in     = '0;
      rsp_last_in      = 1'b1;

      if (busy_ff) begin
         // steps past the output limit rotate without an item
         if (int'(step_ff) >= MAX_RESULTS || rsp_free) begin
            do_rotate = 1'b1;
            if (int'(step_ff) < MAX_RESULTS) begin
               rsp_load         = 1'b1;
               rsp_has_value_in = 1'b1;
               rsp_index_in     = INDEX_W'(step_ff);
               rsp_value_in     = cell_val[0];
               rsp_last_in      = (int'(step_ff) + 1 == n_emit);
            end
            step_in = step_ff + 1'b1;
            if (int'(step_ff) + 1 == int'(count_ff)) begin
               busy_in = 1'b0;
            end
         end
      end else if (req_accept) begin
         rsp_load = 1'b1;
         case (req_op)
            OP_APPEND, OP_INSERT: begin
               ins_pos = (req_op == OP_APPEND) ? cnt_ext : pos_ext;
               if (ins_pos > cnt_ext) begin
                  rsp_status_in = ST_INVALID;
               end else if (int'(count_ff) == CAPACITY) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  do_insert = 1'b1;
                  edit_pos  = ins_pos[CW-1:0];
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_REMOVE_LAST: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_ERASE: begin
               if (pos_ext >= cnt_ext) begin
                  rsp_status_in = ST_INVALID;
               end else begin
                  do_erase = 1'b1;
                  edit_pos = pos_ext[CW-1:0];
                  count_in = count_ff - 1'b1;
               end
            end
            OP_READ_ALL: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_load = 1'b0;
                  busy_in  = 1'b1;
                  step_in  = '0;
               end
            end
            default: begin
               rsp_status_in = ST_INVALID;
            end
         endcase
         rsp_count_in = COUNT_W'(count_in);
      end
   end

   // row of cells, each picking its next word from its neighbors, the request value or the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic [CELL_SEL_W-1:0] sel;
      word_type              left_val;
      word_type              right_val;

      if (i == 0) begin : g_first
         assign left_val = cell_val[0];
      end else begin : g_inner_l
         assign left_val = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_final
         assign right_val = cell_val[i];
      end else begin : g_inner_r
         assign right_val = cell_val[i+1];
      end

      always_comb begin
         sel = CELL_HOLD;
         if (do_insert) begin
            if (IDX == edit_pos) begin
               sel = CELL_LOAD;
            end else if (IDX > edit_pos && IDX <= count_ff) begin
               sel = CELL_LEFT;
            end
         end else if (do_erase) begin
            if (IDX >= edit_pos && i + 1 < int'(count_ff)) begin
               sel = CELL_RIGHT;
            end
         end else if (do_rotate) begin
            // head wraps around to the tail of the stored words
            if (i + 1 < int'(count_ff)) begin
               sel = CELL_RIGHT;
            end else if (i + 1 == int'(count_ff)) begin
               sel = CELL_HEAD;
            end
         end
      end

      pli_cell u_cell (
         .clock     (clock),
         .sel       (sel),
         .load_val  (req_value),
         .left_val  (left_val),
         .right_val (right_val),
         .head_val  (cell_val[0]),
         .val       (cell_val[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_count_ff     <= rsp_count_in;
         rsp_has_value_ff <= rsp_has_value_in;
         rsp_index_ff     <= rsp_index_in;
         rsp_value_ff     <= rsp_value_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_has_value  = rsp_has_value_ff;
   assign rsp_item_index = rsp_index_ff;
   assign rsp_item_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0)
      else $error("read all running on an empty list");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CAPACITY)
      else $error("count above capacity");

   a_edit_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op != OP_READ_ALL) |=> rsp_valid_ff)
      else $error("accepted edit gave no result item");

   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> $stable(count_ff))
      else $error("count changed during read all");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff < count_ff)
      else $error("read all step past the stored words");

endmodule

// ===== tb/sv/list_checker.sv =====
`timescale 1ns / 1ps

module list_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [pli_pkg::OP_W-1:0]           req_op,
   input  logic [pli_pkg::POS_W-1:0]          req_position,
   input  logic signed [pli_pkg::VAL_W-1:0]   req_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [pli_pkg::STAT_W-1:0]         rsp_status,
   input  logic [pli_pkg::COUNT_W-1:0]        rsp_count,
   input  logic                               rsp_has_value,
   input  logic [pli_pkg::INDEX_W-1:0]        rsp_item_index,
   input  logic signed [pli_pkg::VAL_W-1:0]   rsp_item_value,
   input  logic                               rsp_last,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 checked_count
);
   import pli_pkg::*;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] count;
      logic               has_value;
      logic [INDEX_W-1:0] index;
      word_type           value;
      logic               last;
   } list_result_type;

   // shadow copy of the list held by the block
   word_type        list_words [CAPACITY];
   int              list_len;
   list_result_type due_results [$];

   initial begin
      error_count = 0;
      pending_count = 0;
      checked_count = 0;
      list_len = 0;
   end

   function automatic list_result_type make_result(logic [STAT_W-1:0] status,
                                                   logic has_value, int index,
                                                   word_type value, logic last);
      list_result_type r;
      r.status = status;
      r.count = COUNT_W'(list_len);
      r.has_value = has_value;
      r.index = INDEX_W'(index);
      r.value = value;
      r.last = last;
      return r;
   endfunction

   function automatic void add_due(list_result_type r);
      due_results = {due_results, r};
   endfunction

   function automatic logic [STAT_W-1:0] insert_word(int pos, word_type w);
      if (pos > list_len) return ST_INVALID;
      if (list_len >= CAPACITY) return ST_FULL;
      for (int i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
      list_words[pos] = w;
      list_len++;
      return ST_OK;
   endfunction

   function automatic logic [STAT_W-1:0] erase_word(int pos);
      if (pos >= list_len) return ST_INVALID;
      for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
      list_len--;
      return ST_OK;
   endfunction

   task automatic apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, word_type w);
      logic [STAT_W-1:0] status;
      int n;
      case (op)
         OP_APPEND: status = insert_word(list_len, w);
         OP_REMOVE_LAST: begin
            if (list_len == 0) begin
               status = ST_EMPTY;
            end else begin
               list_len--;
               status = ST_OK;
            end
         end
         OP_INSERT: status = insert_word(int'(pos), w);
         OP_ERASE: status = erase_word(int'(pos));
         OP_READ_ALL: begin
            if (list_len == 0) begin
               add_due(make_result(ST_EMPTY, 1'b0, 0, '0, 1'b1));
            end else begin
               n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
               for (int i = 0; i < n; i++)
                  add_due(make_result(ST_OK, 1'b1, i, list_words[i], i == n - 1));
            end
            return;
         end
         default: status = ST_INVALID;
      endcase
      add_due(make_result(status, 1'b0, 0, '0, 1'b1));
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      list_result_type want;
      checked_count++;
      if (due_results.size() == 0) begin
         $error("unexpected result item: status %0d count %0d", rsp_status, rsp_count);
         error_count++;
         return;
      end
      want = due_results.pop_front();
      compare_field("status", 32'(want.status), 32'(rsp_status));
      compare_field("count", 32'(want.count), 32'(rsp_count));
      compare_field("has_value", 32'(want.has_value), 32'(rsp_has_value));
      compare_field("item_index", 32'(want.index), 32'(rsp_item_index));
      compare_field("item_value", want.value, rsp_item_value);
      compare_field("last", 32'(want.last), 32'(rsp_last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         due_results.delete();
      end else begin
         if (req_valid && !req_stall) apply_list_op(req_op, req_position, req_value);
         if (rsp_valid && !rsp_stall) check_result();
      end
      pending_count = due_results.size();
   end

endmodule

// ===== tb/sv/positional_list_insert_erase_test.sv =====
`timescale 1ns / 1ps

module positional_list_insert_erase_test;
   import pli_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 90;
   localparam int QUIET_ITEMS = 30;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int POS_MAX = 2 ** POS_W - 1;
   localparam int OP_UNDEF_FIRST = OP_READ_ALL + 1;
   localparam int OP_UNDEF_LAST = 2 ** OP_W - 1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VAL_W-1:0]   req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STAT_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]        rsp_count;
   logic                      rsp_has_value;
   logic [INDEX_W-1:0]        rsp_item_index;
   logic signed [VAL_W-1:0]   rsp_item_value;
   logic                      rsp_last;

   int error_count;
   int pending_count;
   int checked_count;

   // list length as seen by the stimulus, used to aim positions
   int list_len = 0;
   int items_sent = 0;
   int fill_count = 0;
   int quiet_cycles = 0;
   bit idling_on = 1'b1;

   always #5 clock = ~clock;

   positional_list_insert_erase #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_has_value(rsp_has_value),
      .rsp_item_index(rsp_item_index),
      .rsp_item_value(rsp_item_value),
      .rsp_last(rsp_last)
   );

   list_checker #(
      .CAPACITY(CAPACITY)
   ) list_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_has_value(rsp_has_value),
      .rsp_item_index(rsp_item_index),
      .rsp_item_value(rsp_item_value),
      .rsp_last(rsp_last),
      .error_count(error_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   // receiver stalls in bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, word_type value);
      int gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_position <= pos;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      items_sent++;
      case (op)
         OP_APPEND: if (list_len < CAPACITY) list_len++;
         OP_INSERT: if (pos <= list_len && list_len < CAPACITY) list_len++;
         OP_REMOVE_LAST: if (list_len > 0) list_len--;
         OP_ERASE: if (pos < list_len) list_len--;
         default: ;
      endcase
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // grow to capacity, then probe the full list
   task automatic fill_list();
      while (list_len < CAPACITY) begin
         if ($urandom_range(0, 1))
            send_item(OP_APPEND, $urandom_range(0, POS_MAX), $urandom);
         else
            send_item(OP_INSERT, $urandom_range(0, list_len), $urandom);
      end
      fill_count++;
      send_item(OP_APPEND, $urandom_range(0, POS_MAX), $urandom);
      send_item(OP_INSERT, $urandom_range(0, CAPACITY), $urandom);
      send_item(OP_INSERT, $urandom_range(CAPACITY + 1, POS_MAX), $urandom);
      send_item(OP_READ_ALL, $urandom_range(0, POS_MAX), $urandom);
   endtask

   // shrink to empty, then probe the empty list
   task automatic drain_list();
      while (list_len > 0) begin
         if ($urandom_range(0, 1))
            send_item(OP_REMOVE_LAST, $urandom_range(0, POS_MAX), $urandom);
         else
            send_item(OP_ERASE, $urandom_range(0, list_len - 1), $urandom);
      end
      send_item(OP_REMOVE_LAST, $urandom_range(0, POS_MAX), $urandom);
      send_item(OP_ERASE, $urandom_range(0, POS_MAX), $urandom);
      send_item(OP_READ_ALL, $urandom_range(0, POS_MAX), $urandom);
   endtask

   // mostly sensible edits, with some bad positions and undefined ops
   task automatic mixed_ops();
      logic [OP_W-1:0] op;
      int pos;
      repeat ($urandom_range(4, 12)) begin
         if ($urandom_range(0, 9) == 0)
            op = $urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST);
         else
            op = $urandom_range(OP_APPEND, OP_READ_ALL);
         if ($urandom_range(0, 3) == 0)
            pos = $urandom_range(0, POS_MAX);
         else
            pos = $urandom_range(0, list_len);
         send_item(op, pos, $urandom);
      end
   endtask

   initial begin
      int random_end;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_item(OP_READ_ALL, 0, 0);
      send_item(OP_REMOVE_LAST, 0, 0);
      send_item(OP_ERASE, 0, 0);
      send_item(OP_INSERT, 1, 32'h1234_5678);
      // extremes of the value, inserts at head, middle and end
      send_item(OP_INSERT, 0, 32'h7fff_ffff);
      send_item(OP_APPEND, POS_MAX, 32'h8000_0000);
      send_item(OP_INSERT, 1, 32'h0000_0000);
      send_item(OP_APPEND, 0, 32'hffff_ffff);
      send_item(OP_INSERT, 4, 32'h5555_5555);
      send_item(OP_INSERT, 2, 32'haaaa_aaaa);
      send_item(OP_READ_ALL, 0, 0);
      send_item(OP_ERASE, 0, 0);
      send_item(OP_ERASE, 4, 0);
      send_item(OP_ERASE, POS_MAX, 0);
      send_item(OP_INSERT, POS_MAX, 32'h1);
      for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++)
         send_item(op, 0, 0);
      send_item(OP_REMOVE_LAST, 0, 0);
      send_item(OP_READ_ALL, 0, 0);

      // hold off until the block has answered everything
      wait_for_results();

      random_end = items_sent + RANDOM_ITEMS;
      fill_list();
      while (items_sent < random_end) begin
         if (items_sent >= random_end - QUIET_ITEMS)
            idling_on = 1'b0;
         else
            idling_on = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 3))
            0: fill_list();
            1: drain_list();
            default: mixed_ops();
         endcase
         if (idling_on && $urandom_range(0, 5) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d operations sent, %0d result items checked", items_sent, checked_count);
      $display("list filled to capacity %0d times, with empty, full and bad-position cases",
               fill_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pli_pkg.sv
rtl/pli_cell.sv
rtl/positional_list_insert_erase.sv
tb/sv/list_checker.sv
tb/sv/positional_list_insert_erase_test.sv
